@@ rtl/qpht_pkg.sv @@
// Shared types and codes for the quadratic probe hash table.
// Beat structs, operation and status codes, field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qpht_pkg;

  localparam int OP_W      = 2;
  localparam int KEY_W     = 31;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 4;
  localparam int DEF_SLOTS = 16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } in_beat_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } out_beat_t;

endpackage

`default_nettype wire

@@ rtl/qpht_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Parameters for width and depth; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module qpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/qpht_mod.sv @@
// Home slot unit: key mod SLOTS. A mask when SLOTS is a power of two,
// otherwise four key bits a cycle from the top. Depends on qpht_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qpht_mod #(
  parameter int SLOTS = qpht_pkg::DEF_SLOTS,
  parameter int IDX_W = $clog2(SLOTS)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [qpht_pkg::KEY_W-1:0] key,
  output logic                          done,
  output logic      [IDX_W-1:0]         rem
);

  localparam bit POW2     = (SLOTS & (SLOTS - 1)) == 0;
  localparam int DIGIT_W  = 4;
  localparam int N_DIGITS = (qpht_pkg::KEY_W + DIGIT_W - 1) / DIGIT_W;
  localparam int SH_W     = N_DIGITS * DIGIT_W;
  localparam int CNT_W    = (N_DIGITS > 1) ? $clog2(N_DIGITS) : 1;

  generate
    if (POW2) begin : g_mask
      logic             done_r;
      logic [IDX_W-1:0] rem_r;

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem_r <= key[IDX_W-1:0];
        end
      end

      assign done = done_r;
      assign rem  = rem_r;
    end else begin : g_digit
      logic             run_r, run_nxt;
      logic             done_r, done_nxt;
      logic [CNT_W-1:0] cnt_r, cnt_nxt;
      logic [SH_W-1:0]  sh_r, sh_nxt;
      logic [IDX_W-1:0] rem_r, rem_nxt;
      logic [IDX_W-1:0] rem_step;

      always_comb begin
        logic [IDX_W:0] acc;
        acc = {1'b0, rem_r};
        for (int b = 0; b < DIGIT_W; b++) begin
          acc = {acc[IDX_W-1:0], sh_r[SH_W-1-b]};
          if (acc >= (IDX_W+1)'(SLOTS)) begin
            acc = acc - (IDX_W+1)'(SLOTS);
          end
        end
        rem_step = acc[IDX_W-1:0];
      end

      always_comb begin
        run_nxt  = run_r;
        done_nxt = 1'b0;
        cnt_nxt  = cnt_r;
        sh_nxt   = sh_r;
        rem_nxt  = rem_r;
        if (start) begin
          run_nxt = 1'b1;
          cnt_nxt = '0;
          sh_nxt  = SH_W'(key);
          rem_nxt = '0;
        end else if (run_r) begin
          rem_nxt = rem_step;
          sh_nxt  = sh_r << DIGIT_W;
          cnt_nxt = cnt_r + 1'b1;
          if (cnt_r == CNT_W'(N_DIGITS - 1)) begin
            run_nxt  = 1'b0;
            done_nxt = 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          run_r  <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          run_r  <= run_nxt;
          done_r <= done_nxt;
          cnt_r  <= cnt_nxt;
        end
      end

      always_ff @(posedge clk) begin
        sh_r  <= sh_nxt;
        rem_r <= rem_nxt;
      end

      assign done = done_r;
      assign rem  = rem_r;
    end
  endgenerate

endmodule

`default_nettype wire

@@ rtl/quadratic_probe_hash_table_unit.sv @@
// Top level of the quadratic probe hash table: sequencer around one entry RAM.
// Depends on qpht_pkg, qpht_ram and qpht_mod.
//
//   channel   ports                        handshake
//   input     start, busy, in_data         beat taken when start && !busy
//   result    out_valid, out_data          one-cycle strobe, no back-pressure
//
// A request holds busy through the home slot unit and then through P probes,
// P being the number of probes (1 to SLOTS), taken one probe a cycle through
// the RAM read port.
// An unknown op answers in the cycle after it is taken and never raises busy.
// After reset a clearing pass writes every slot and holds busy high.
// The result appears the cycle busy falls; the receiver cannot stall it.
`timescale 1ns / 1ps
`default_nettype none

module quadratic_probe_hash_table_unit #(
  parameter int SLOTS = qpht_pkg::DEF_SLOTS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire qpht_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  output qpht_pkg::out_beat_t      out_data
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam int ENT_W = qpht_pkg::KEY_W + 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_MOD   = 2'd2;
  localparam logic [1:0] S_PROBE = 2'd3;

  logic [1:0]                  state_r, state_nxt;
  logic [IDX_W-1:0]            clr_r, clr_nxt;
  logic [qpht_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [qpht_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic [IDX_W-1:0]            s_r, s_nxt;
  logic [IDX_W-1:0]            step_r, step_nxt;
  logic [IDX_W-1:0]            i_r, i_nxt;
  logic                        out_valid_r, out_valid_nxt;
  qpht_pkg::out_beat_t         out_r, out_nxt;

  logic                        accept;
  logic                        mod_start;
  logic                        mod_done;
  logic [IDX_W-1:0]            mod_rem;

  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [ENT_W-1:0]            ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [ENT_W-1:0]            ram_rdata;

  logic [IDX_W:0]              s_sum, step_sum;
  logic [IDX_W-1:0]            s_adv, step_adv;
  logic                        ent_valid, ent_hit, last_probe;

  assign accept = start && (state_r == S_IDLE);

  qpht_mod #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .key   (in_data.key),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  qpht_ram #(
    .WIDTH (ENT_W),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // advance slot by 2i+1 and the step by two, both mod SLOTS
  always_comb begin
    s_sum    = {1'b0, s_r} + {1'b0, step_r};
    s_adv    = (s_sum >= (IDX_W+1)'(SLOTS)) ? IDX_W'(s_sum - (IDX_W+1)'(SLOTS))
                                            : s_sum[IDX_W-1:0];
    step_sum = {1'b0, step_r} + (IDX_W+1)'(2);
    step_adv = (step_sum >= (IDX_W+1)'(SLOTS)) ?
               IDX_W'(step_sum - (IDX_W+1)'(SLOTS)) : step_sum[IDX_W-1:0];
  end

  assign ent_valid  = ram_rdata[qpht_pkg::KEY_W];
  assign ent_hit    = ent_valid && (ram_rdata[qpht_pkg::KEY_W-1:0] == key_r);
  assign last_probe = (i_r == IDX_W'(SLOTS - 1));

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    s_nxt         = s_r;
    step_nxt      = step_r;
    i_nxt         = i_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mod_start     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = s_r;
    ram_wdata     = '0;
    ram_raddr     = s_adv;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (in_data.op inside {qpht_pkg::OP_INSERT, qpht_pkg::OP_DELETE,
                                 qpht_pkg::OP_SEARCH}) begin
            mod_start = 1'b1;
            op_nxt    = in_data.op;
            key_nxt   = in_data.key;
            state_nxt = S_MOD;
          end else begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = qpht_pkg::ST_MISS;
            out_nxt.slot   = '0;
          end
        end
      end
      S_MOD: begin
        ram_raddr = mod_rem;
        if (mod_done) begin
          s_nxt     = mod_rem;
          step_nxt  = IDX_W'(1);
          i_nxt     = '0;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        out_nxt.slot = '0;
        if (op_r == qpht_pkg::OP_INSERT) begin
          if (!ent_valid) begin
            ram_we         = 1'b1;
            ram_wdata      = {1'b1, key_r};
            out_valid_nxt  = 1'b1;
            out_nxt.status = qpht_pkg::ST_OK;
            out_nxt.slot   = qpht_pkg::SLOT_W'(s_r);
          end else if (last_probe) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = qpht_pkg::ST_FULL;
          end
        end else begin
          if (ent_hit) begin
            ram_we         = (op_r == qpht_pkg::OP_DELETE);
            ram_wdata      = {1'b0, key_r};
            out_valid_nxt  = 1'b1;
            out_nxt.status = qpht_pkg::ST_OK;
            out_nxt.slot   = qpht_pkg::SLOT_W'(s_r);
          end else if (!ent_valid || last_probe) begin
            out_valid_nxt  = 1'b1;
            out_nxt.status = qpht_pkg::ST_MISS;
          end
        end
        if (out_valid_nxt) begin
          state_nxt = S_IDLE;
        end else begin
          s_nxt    = s_adv;
          step_nxt = step_adv;
          i_nxt    = i_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    s_r    <= s_nxt;
    step_r <= step_nxt;
    i_r    <= i_nxt;
    out_r  <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PROBE |-> ({1'b0, s_r} < (IDX_W+1)'(SLOTS)))
    else $error("probe slot out of range");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != qpht_pkg::ST_OK |-> out_data.slot == '0)
    else $error("slot nonzero on a failed request");

  a_accept_answered: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy || out_valid)
    else $error("accepted beat neither in progress nor answered");

  a_write_in_probe: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_CLEAR || state_r == S_PROBE)
    else $error("entry write outside clearing or probing");

endmodule

`default_nettype wire
